// File: hdl/ptd_pkg.sv
// shared types and constants for the periodic task dispatcher
// queue item and result formats passed between front end, back end and top level
// no dependencies
package ptd_pkg;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_FW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_REFUSE,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  task_id;
        logic [31:0] period;
        logic [7:0]  priority_req;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic       run_valid;
        logic [7:0] run_task;
        logic       last;
    } result_t;

endpackage

// File: hdl/ptd_front.sv
// front end of the periodic task dispatcher: takes transactions, classifies them
// and holds them in a short queue for the back end
// depends on ptd_pkg
module ptd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            op,
    input  logic [7:0]      task_id,
    input  logic [31:0]     period,
    input  logic [7:0]      priority_req,
    output logic            q_valid,
    output ptd_pkg::cmd_t   q_item,
    input  logic            pop
);
    import ptd_pkg::*;

    cmd_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_FW-1:0] fill_reg, fill_next;
    cmd_t                item;
    logic                push;

    // zero period is refused up front, the full check needs the table
    always_comb
    begin
        item.task_id      = task_id;
        item.period       = period;
        item.priority_req = priority_req;
        if (op == OP_TICK)
        begin
            item.kind = CMD_TICK;
        end
        else if (period == 32'd0)
        begin
            item.kind = CMD_REFUSE;
        end
        else
        begin
            item.kind = CMD_ADD;
        end
    end

    assign busy    = (fill_reg == QUEUE_FW'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (fill_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && q_valid))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && pop && q_valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// File: hdl/ptd_back.sv
// back end of the periodic task dispatcher: sorted task table, insertion and
// the tick walk that rotates the table one entry a cycle
// depends on ptd_pkg
module ptd_back #(
    parameter int MAX_TASKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ptd_pkg::cmd_t     q_item,
    output logic              pop,
    output logic              strobe,
    output ptd_pkg::result_t  result
);
    import ptd_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        logic [7:0]  task_id;
        logic [31:0] period;
        logic [31:0] countdown;
        logic [7:0]  priority_req;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  rem_reg;
    logic           pend_valid_reg;
    logic [7:0]     pend_id_reg;
    logic           strobe_reg;
    result_t        result_reg;

    entry_t         entry_reg  [MAX_TASKS];
    entry_t         entry_next [MAX_TASKS];
    logic [MAX_TASKS-1:0] le;
    entry_t         head_new;
    entry_t         new_entry;
    logic           head_due;
    logic           full;
    logic           do_insert;
    logic           do_step;

    assign full      = (count_reg == CW'(MAX_TASKS));
    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign do_insert = pop && (q_item.kind == CMD_ADD) && !full;
    assign do_step   = (state_reg == S_WALK);
    assign head_due  = (entry_reg[0].countdown == 32'd0);

    always_comb
    begin
        head_new = entry_reg[0];
        head_new.countdown = head_due ? entry_reg[0].period - 32'd1
                                      : entry_reg[0].countdown - 32'd1;
        new_entry.task_id      = q_item.task_id;
        new_entry.period       = q_item.period;
        new_entry.countdown    = q_item.period;
        new_entry.priority_req = q_item.priority_req;
    end

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_entry
        logic   prev_le;
        entry_t up_e;
        entry_t dn_e;

        // stored entries with priority not above the new one form a prefix
        assign le[i] = (CW'(i) < count_reg) &&
                       (entry_reg[i].priority_req <= q_item.priority_req);

        if (i == 0)
        begin : g_first
            assign prev_le = 1'b1;
            assign up_e    = entry_reg[i];
        end
        else
        begin : g_rest
            assign prev_le = le[i-1];
            assign up_e    = entry_reg[i-1];
        end

        if (i == MAX_TASKS - 1)
        begin : g_tail
            assign dn_e = head_new;
        end
        else
        begin : g_body
            assign dn_e = (CW'(i + 1) == count_reg) ? head_new : entry_reg[i+1];
        end

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (do_insert)
            begin
                if (!le[i])
                begin
                    entry_next[i] = prev_le ? new_entry : up_e;
                end
            end
            else if (do_step)
            begin
                // rotate: processed head goes to the last occupied slot
                entry_next[i] = dn_e;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.kind == CMD_TICK)
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_reg           <= 1'b1;
                                result_reg.kind      <= KIND_TICK;
                                result_reg.accepted  <= 1'b0;
                                result_reg.run_valid <= 1'b0;
                                result_reg.run_task  <= '0;
                                result_reg.last      <= 1'b1;
                            end
                            else
                            begin
                                state_reg      <= S_WALK;
                                rem_reg        <= count_reg;
                                pend_valid_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            strobe_reg           <= 1'b1;
                            result_reg.kind      <= KIND_ADD;
                            result_reg.accepted  <= do_insert;
                            result_reg.run_valid <= 1'b0;
                            result_reg.run_task  <= '0;
                            result_reg.last      <= 1'b1;
                            if (do_insert)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                S_WALK:
                begin
                    // hold one dispatch back so the final one can carry last
                    if (head_due)
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_reg           <= 1'b1;
                            result_reg.kind      <= KIND_TICK;
                            result_reg.accepted  <= 1'b0;
                            result_reg.run_valid <= 1'b1;
                            result_reg.run_task  <= pend_id_reg;
                            result_reg.last      <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_id_reg    <= entry_reg[0].task_id;
                    end
                    rem_reg <= rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    strobe_reg           <= 1'b1;
                    result_reg.kind      <= KIND_TICK;
                    result_reg.accepted  <= 1'b0;
                    result_reg.run_valid <= pend_valid_reg;
                    result_reg.run_task  <= pend_valid_reg ? pend_id_reg : 8'd0;
                    result_reg.last      <= 1'b1;
                    pend_valid_reg       <= 1'b0;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count above table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rem_reg != '0))
        else $error("walk with no entries left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |=> (strobe_reg && result_reg.last))
        else $error("tick did not end with a last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.kind == KIND_ADD) |->
            (result_reg.last && !result_reg.run_valid))
        else $error("malformed add response");

endmodule

// File: hdl/periodic_task_dispatcher_unit.sv
// top level of the periodic task dispatcher (time triggered cooperative scheduler)
// instantiates ptd_front and ptd_back, depends on ptd_pkg
//
// usage:
//   a transaction is taken at a rising edge with start high and busy low;
//   op selects add task or one scheduler tick, task_id, period and
//   priority_req matter only for an add
//   each result is on kind, accepted, run_valid, run_task and last for exactly
//   one cycle while strobe is high; the receiver cannot stall, nothing waits
//   on it
//   an add gives one response, registered as it leaves the queue, refused when
//   the table is full or the period is zero
//   a tick walks the table one entry a cycle, holding the back end through the
//   walk and a closing flush state (an empty table gets neither); dispatches come out
//   in priority order, the final one with last set, or one empty result
//   a two entry queue sits between front and back, busy rises when it is full
//   reset clears the task count and the queue; table contents are not cleared
module periodic_task_dispatcher_unit #(
    parameter int MAX_TASKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  task_id,
    input  logic [31:0] period,
    input  logic [7:0]  priority_req,
    output logic        strobe,
    output logic        kind,
    output logic        accepted,
    output logic        run_valid,
    output logic [7:0]  run_task,
    output logic        last
);
    import ptd_pkg::*;

    logic    q_valid;
    cmd_t    q_item;
    logic    pop;
    result_t result;

    ptd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .task_id      (task_id),
        .period       (period),
        .priority_req (priority_req),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop)
    );

    ptd_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );

    assign kind      = result.kind;
    assign accepted  = result.accepted;
    assign run_valid = result.run_valid;
    assign run_task  = result.run_task;
    assign last      = result.last;

endmodule
